FILE: design/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// SVPWM package
// Shared constants and types for the space-vector compare-time pipeline.
// ----------------------------------------------------------------------------
package svpwm_pkg;

   localparam logic [14:0] ROOT3_GAIN   = 15'h6ED9;
   localparam logic [15:0] PERIOD_RESET = 16'd5000;
   localparam int          DIV_STAGES  = 16;

   // Register byte addresses on the configuration port.
   localparam logic [2:0]  ADDR_PWM_PERIOD = 3'd0;

   // Sector codes, 4c + 2b + a.
   localparam logic [2:0]  SECTOR_ORIGIN = 3'd0;
   localparam logic [2:0]  SECTOR_ONE    = 3'd1;
   localparam logic [2:0]  SECTOR_TWO    = 3'd2;
   localparam logic [2:0]  SECTOR_THREE  = 3'd3;
   localparam logic [2:0]  SECTOR_FOUR   = 3'd4;
   localparam logic [2:0]  SECTOR_FIVE   = 3'd5;
   localparam logic [2:0]  SECTOR_SIX    = 3'd6;
   localparam logic [2:0]  SECTOR_SEVEN  = 3'd7;

   typedef logic [15:0] div_mag_type;
   typedef logic [16:0] div_den_type;

endpackage

FILE: design/svpwm_div.sv
// ----------------------------------------------------------------------------
// SVPWM rescale divider
// Pipelined restoring divider: quotient = (mag * 2^15) / den, one quotient
// bit per register stage. The divisor must exceed 2^15.
// ----------------------------------------------------------------------------
module svpwm_div (
   input  logic                  clock,
   input  logic                  en,
   input  svpwm_pkg::div_mag_type mag,
   input  svpwm_pkg::div_den_type den,
   output svpwm_pkg::div_mag_type quotient
);
   import svpwm_pkg::*;

   logic [16:0] rem_ff [DIV_STAGES];
   logic [16:0] den_ff [DIV_STAGES];
   logic [15:0] quo_ff [DIV_STAGES];
   logic [16:0] rem_in [DIV_STAGES];
   logic [16:0] den_in [DIV_STAGES];
   logic [15:0] quo_in [DIV_STAGES];

   // The top 15 dividend bits are below the divisor, so they seed the
   // remainder; the first stage brings in mag[0], later stages bring in zeros.
   always_comb begin
      logic [17:0] trial;
      trial = '0;
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (k == 0) begin
            trial     = {2'b00, mag[15:1], mag[0]};
            den_in[k] = den;
            quo_in[k] = '0;
         end else begin
            trial     = {rem_ff[k-1], 1'b0};
            den_in[k] = den_ff[k-1];
            quo_in[k] = {quo_ff[k-1][14:0], 1'b0};
         end
         if (trial >= {1'b0, den_in[k]}) begin
            rem_in[k]    = 17'(trial - {1'b0, den_in[k]});
            quo_in[k][0] = 1'b1;
         end else begin
            rem_in[k] = trial[16:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign quotient = quo_ff[DIV_STAGES-1];

endmodule

FILE: design/svpwm_compare_times.sv
// Throughput: one sample per cycle; the pipeline advances as one, held only by rsp_tready.
// The depth is set by the 16-stage rescale divider plus six arithmetic stages.
// Reset clears all valid bits and loads pwm_period with 5000; no clearing pass.
// ----------------------------------------------------------------------------
// SVPWM compare times
// Sector search, overmodulation rescale and compare-count routing for a
// seven-segment space-vector modulator, fully pipelined.
// ----------------------------------------------------------------------------
module svpwm_compare_times (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // alpha_voltage[15:0], beta_voltage[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // sector_code[2:0], compare_one[17:3], compare_two[32:18],
   // compare_three[47:33], overmodulated[48], zero pad[55:49]
   output logic [55:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import svpwm_pkg::*;

   logic        en;
   logic [15:0] period_ff;

   // Configuration port
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == ADDR_PWM_PERIOD) begin
         period_ff <= csr_pwdata[15:0];
      end
   end
   assign csr_prdata = (csr_paddr == ADDR_PWM_PERIOD) ? {16'd0, period_ff} : 32'd0;

   // The whole pipeline moves whenever the output register can take a result.
   logic out_valid_ff;
   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;

   // Stage 1: sqrt(3) product
   logic               v1_ff;
   logic signed [31:0] prod_ff;
   logic signed [15:0] beta1_ff;

   // Stage 2: scaled alpha
   logic               v2_ff;
   logic signed [17:0] as_ff;
   logic signed [17:0] beta2_ff;
   logic signed [32:0] prod_b;
   logic signed [32:0] as_full;

   // Stage 3: sector and active times
   logic               v3_ff;
   logic [2:0]         code3_ff;
   logic signed [17:0] t4_3_ff, t6_3_ff;
   logic               over3_ff;
   logic signed [18:0] ypre, zpre, ysum, zsum;
   logic signed [17:0] y_in, z_in, t4_in, t6_in;
   logic signed [18:0] sum_in;
   logic [2:0]         code_in;
   logic [15:0]        mag4, mag6;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= $signed(req_tdata[15:0]) * $signed({1'b0, ROOT3_GAIN});
         beta1_ff <= $signed(req_tdata[31:16]);
         as_ff    <= as_full[17:0];
         beta2_ff <= 18'(beta1_ff);
         code3_ff <= code_in;
         t4_3_ff  <= t4_in;
         t6_3_ff  <= t6_in;
         over3_ff <= sum_in > 19'sd32768;
      end
   end

   // Division by 2^14 truncating toward zero.
   assign prod_b  = 33'(prod_ff) + (prod_ff[31] ? 33'sd16383 : 33'sd0);
   assign as_full = prod_b >>> 14;

   always_comb begin
      ypre = 19'(beta2_ff) + 19'(as_ff);
      zpre = 19'(beta2_ff) - 19'(as_ff);
      ysum = ypre + (ypre[18] ? 19'sd1 : 19'sd0);
      zsum = zpre + (zpre[18] ? 19'sd1 : 19'sd0);
      y_in = ysum[18:1];
      z_in = zsum[18:1];
      code_in = {(-as_ff) > beta2_ff, as_ff > beta2_ff, beta2_ff > 18'sd0};
      case (code_in)
         SECTOR_ONE:   begin t4_in = z_in;      t6_in = y_in;      end
         SECTOR_TWO:   begin t4_in = y_in;      t6_in = -beta2_ff; end
         SECTOR_THREE: begin t4_in = -z_in;     t6_in = beta2_ff;  end
         SECTOR_FOUR:  begin t4_in = -beta2_ff; t6_in = z_in;      end
         SECTOR_FIVE:  begin t4_in = beta2_ff;  t6_in = -y_in;     end
         SECTOR_SIX:   begin t4_in = -y_in;     t6_in = -z_in;     end
         default:      begin t4_in = '0;        t6_in = '0;        end
      endcase
      sum_in = 19'(t4_in) + 19'(t6_in);
   end

   // Rescale dividers, fed by stage 3; side data travels alongside.
   logic signed [18:0] sum3;
   assign sum3 = 19'(t4_3_ff) + 19'(t6_3_ff);
   assign mag4 = t4_3_ff[17] ? 16'(-t4_3_ff) : t4_3_ff[15:0];
   assign mag6 = t6_3_ff[17] ? 16'(-t6_3_ff) : t6_3_ff[15:0];

   div_mag_type q4, q6;
   svpwm_div u_div4 (.clock(clock), .en(en), .mag(mag4), .den(sum3[16:0]), .quotient(q4));
   svpwm_div u_div6 (.clock(clock), .en(en), .mag(mag6), .den(sum3[16:0]), .quotient(q6));

   logic               dv_ff   [DIV_STAGES];
   logic [2:0]         dcode_ff[DIV_STAGES];
   logic signed [17:0] dt4_ff  [DIV_STAGES];
   logic signed [17:0] dt6_ff  [DIV_STAGES];
   logic               dover_ff[DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) dv_ff[k] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= v3_ff;
         for (int k = 1; k < DIV_STAGES; k++) dv_ff[k] <= dv_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dcode_ff[0] <= code3_ff;
         dt4_ff[0]   <= t4_3_ff;
         dt6_ff[0]   <= t6_3_ff;
         dover_ff[0] <= over3_ff;
         for (int k = 1; k < DIV_STAGES; k++) begin
            dcode_ff[k] <= dcode_ff[k-1];
            dt4_ff[k]   <= dt4_ff[k-1];
            dt6_ff[k]   <= dt6_ff[k-1];
            dover_ff[k] <= dover_ff[k-1];
         end
      end
   end

   // Stage 4: pick rescaled or original times, multiply by the period.
   localparam int L = DIV_STAGES - 1;
   logic signed [17:0] t4f, t6f;
   logic signed [16:0] per_s;
   logic               v4_ff;
   logic [2:0]         code4_ff;
   logic               over4_ff;
   logic signed [35:0] ps_ff, p4_ff, p6_ff;
   logic [13:0]        quarter_ff;

   always_comb begin
      if (dover_ff[L]) begin
         t4f = dt4_ff[L][17] ? -$signed({2'b00, q4}) : $signed({2'b00, q4});
         t6f = dt6_ff[L][17] ? -$signed({2'b00, q6}) : $signed({2'b00, q6});
      end else begin
         t4f = dt4_ff[L];
         t6f = dt6_ff[L];
      end
   end
   assign per_s = $signed({1'b0, period_ff});

   // Stage 5: phase times
   logic               v5_ff;
   logic [2:0]         code5_ff;
   logic               over5_ff;
   logic [23:0]        ta_ff, tb_ff, tc_ff;
   logic signed [35:0] ps_b, p4_b, p6_b, ps_q, p4_q, p6_q;
   logic [23:0]        ta_in;

   assign ps_b  = ps_ff + (ps_ff[35] ? 36'sd131071 : 36'sd0);
   assign p4_b  = p4_ff + (p4_ff[35] ? 36'sd65535 : 36'sd0);
   assign p6_b  = p6_ff + (p6_ff[35] ? 36'sd65535 : 36'sd0);
   assign ps_q  = ps_b >>> 17;
   assign p4_q  = p4_b >>> 16;
   assign p6_q  = p6_b >>> 16;
   assign ta_in = {10'd0, quarter_ff} - ps_q[23:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= dv_ff[L];
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         code4_ff   <= dcode_ff[L];
         over4_ff   <= dover_ff[L];
         ps_ff      <= (36'(t4f) + 36'(t6f)) * 36'(per_s);
         p4_ff      <= 36'(t4f) * 36'(per_s);
         p6_ff      <= 36'(t6f) * 36'(per_s);
         quarter_ff <= period_ff[15:2];
         code5_ff   <= code4_ff;
         over5_ff   <= over4_ff;
         ta_ff      <= ta_in;
         tb_ff      <= ta_in + p4_q[23:0];
         tc_ff      <= ta_in + p4_q[23:0] + p6_q[23:0];
      end
   end

   // Stage 6: clamp and route to the channels.
   function automatic logic [14:0] fit(input logic [23:0] t);
      if (t[23])        return 15'd0;
      else if (|t[22:15]) return 15'h7FFF;
      else              return t[14:0];
   endfunction

   logic [14:0] fa, fb, fc, c1_in, c2_in, c3_in;
   assign fa = fit(ta_ff);
   assign fb = fit(tb_ff);
   assign fc = fit(tc_ff);

   always_comb begin
      case (code5_ff)
         SECTOR_ONE:   begin c1_in = fb; c2_in = fa; c3_in = fc; end
         SECTOR_TWO:   begin c1_in = fa; c2_in = fc; c3_in = fb; end
         SECTOR_THREE: begin c1_in = fa; c2_in = fb; c3_in = fc; end
         SECTOR_FOUR:  begin c1_in = fc; c2_in = fb; c3_in = fa; end
         SECTOR_FIVE:  begin c1_in = fc; c2_in = fa; c3_in = fb; end
         SECTOR_SIX:   begin c1_in = fb; c2_in = fc; c3_in = fa; end
         default:      begin c1_in = fa; c2_in = fb; c3_in = fc; end
      endcase
   end

   logic [2:0]  code_o_ff;
   logic [14:0] c1_ff, c2_ff, c3_ff;
   logic        over_o_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         code_o_ff <= code5_ff;
         c1_ff     <= c1_in;
         c2_ff     <= c2_in;
         c3_ff     <= c3_in;
         over_o_ff <= over5_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, over_o_ff, c3_ff, c2_ff, c1_ff, code_o_ff};

`ifndef NO_ASSERTIONS
   a_origin_equal: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && code_o_ff == SECTOR_ORIGIN) |-> (c1_ff == c2_ff && c2_ff == c3_ff))
      else $error("origin result has unequal compare counts");
   a_origin_no_over: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && code_o_ff == SECTOR_ORIGIN) |-> !over_o_ff)
      else $error("overmodulation flagged at the origin");
   a_no_code_seven: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> code3_ff != SECTOR_SEVEN)
      else $error("impossible sector code produced");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!en && v5_ff) |=> v5_ff)
      else $error("pipeline lost an item while stalled");
`endif

endmodule

FILE: bench/svpwm_compare_times_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SVPWM compare times testbench
// Drives alpha/beta samples through the compare-time pipeline under random
// back-pressure, predicts sector, compare counts and overmodulation flag for
// each accepted sample and checks every result in order.
// ----------------------------------------------------------------------------
module svpwm_compare_times_tb;
   import svpwm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic        overmodulated;
      logic [14:0] compare_three;
      logic [14:0] compare_two;
      logic [14:0] compare_one;
      logic [2:0]  sector_code;
   } compare_result_type;

   class compare_scoreboard_type;
      compare_result_type pending[$];
      logic [15:0]     period;
      int              errors;

      function new();
         period = PERIOD_RESET;
         errors = 0;
      endfunction

      function logic [14:0] saturate(longint t);
         if (t < 0) return '0;
         if (t > 32767) return 15'h7FFF;
         return t[14:0];
      endfunction

      // Works out the compare counts for one accepted sample.
      function void note_sample(logic signed [15:0] alpha, logic signed [15:0] beta);
         longint a, b, p, as, x, y, z, t4, t6, sum, ta, tb, tc;
         logic [2:0] code;
         compare_result_type r;
         a = alpha;
         b = beta;
         p = period;
         as = (a * 28377) / 16384;
         x = b;
         y = (b + as) / 2;
         z = (b - as) / 2;
         code = {(-as > b), (as > b), (b > 0)};
         case (code)
            SECTOR_ONE: begin t4 = z; t6 = y; end
            SECTOR_TWO: begin t4 = y; t6 = -x; end
            SECTOR_THREE: begin t4 = -z; t6 = x; end
            SECTOR_FOUR: begin t4 = -x; t6 = z; end
            SECTOR_FIVE: begin t4 = x; t6 = -y; end
            SECTOR_SIX: begin t4 = -y; t6 = -z; end
            default: begin t4 = 0; t6 = 0; end
         endcase
         sum = t4 + t6;
         r.overmodulated = 1'b0;
         if (sum > 32768) begin
            t4 = (t4 * 32768) / sum;
            t6 = (t6 * 32768) / sum;
            r.overmodulated = 1'b1;
         end
         ta = p / 4 - ((t4 + t6) * p) / 131072;
         tb = ta + (t4 * p) / 65536;
         tc = tb + (t6 * p) / 65536;
         r.sector_code = code;
         case (code)
            SECTOR_ONE: begin
               r.compare_one = saturate(tb); r.compare_two = saturate(ta);
               r.compare_three = saturate(tc);
            end
            SECTOR_TWO: begin
               r.compare_one = saturate(ta); r.compare_two = saturate(tc);
               r.compare_three = saturate(tb);
            end
            SECTOR_FOUR: begin
               r.compare_one = saturate(tc); r.compare_two = saturate(tb);
               r.compare_three = saturate(ta);
            end
            SECTOR_FIVE: begin
               r.compare_one = saturate(tc); r.compare_two = saturate(ta);
               r.compare_three = saturate(tb);
            end
            SECTOR_SIX: begin
               r.compare_one = saturate(tb); r.compare_two = saturate(tc);
               r.compare_three = saturate(ta);
            end
            default: begin
               r.compare_one = saturate(ta); r.compare_two = saturate(tb);
               r.compare_three = saturate(tc);
            end
         endcase
         pending.push_back(r);
      endfunction

      function void check_result(logic [55:0] data);
         compare_result_type got, want;
         got = data[48:0];
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.sector_code !== want.sector_code)
            $display("%0t: sector_code expected %0d actual %0d", $time,
                     want.sector_code, got.sector_code);
         if (got.compare_one !== want.compare_one)
            $display("%0t: compare_one expected %0d actual %0d", $time,
                     want.compare_one, got.compare_one);
         if (got.compare_two !== want.compare_two)
            $display("%0t: compare_two expected %0d actual %0d", $time,
                     want.compare_two, got.compare_two);
         if (got.compare_three !== want.compare_three)
            $display("%0t: compare_three expected %0d actual %0d", $time,
                     want.compare_three, got.compare_three);
         if (got.overmodulated !== want.overmodulated)
            $display("%0t: overmodulated expected %0d actual %0d", $time,
                     want.overmodulated, got.overmodulated);
         if (got !== want || data[55:49] !== '0) errors++;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // alpha_voltage[15:0], beta_voltage[31:16]
   logic        rsp_tvalid;
   logic        rsp_tready;
   // sector_code[2:0], compare_one[17:3], compare_two[32:18],
   // compare_three[47:33], overmodulated[48], zero pad[55:49]
   logic [55:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   compare_scoreboard_type board;
   int  cycle_count;
   bit  calm_receiver;
   bit  hold_receiver;

   svpwm_compare_times dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic write_period(logic [15:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_PWM_PERIOD;
      csr_pwdata <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      board.period = value;
   endtask

   // Offers one sample and waits for its transfer; optionally idles first.
   task automatic send_sample(logic [15:0] alpha, logic [15:0] beta, bit may_idle);
      if (may_idle && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {beta, alpha};
      do @(posedge clock); while (!req_tready);
      board.note_sample(alpha, beta);
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_until_drained();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] random_voltage();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(15) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   // Result side: random stalls, a calm stretch and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
         rsp_tready <= !hold_receiver && (calm_receiver || $urandom_range(99) >= 9);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("svpwm_compare_times_tb failed");
         $finish;
      end
   end

   // The hold-off starts while random samples are still being offered.
   initial begin
      int hold_count;
      wait (board != null);
      @(posedge clock);
      while (cycle_count < 550) @(posedge clock);
      hold_receiver = 1'b1;
      for (hold_count = 0; hold_count < 200; hold_count++) @(posedge clock);
      hold_receiver = 1'b0;
   end

   initial begin
      logic [15:0] periods[5];
      logic [15:0] directed[22][2];
      int i, phase, n;
      board = new();
      cycle_count = 0;
      calm_receiver = 1'b0;
      hold_receiver = 1'b0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Origin, axes, every sector, full-scale corners and small magnitudes.
      directed = '{
         '{16'h0000, 16'h0000}, '{16'h7FFF, 16'h0000}, '{16'h8000, 16'h0000},
         '{16'h0000, 16'h7FFF}, '{16'h0000, 16'h8000}, '{16'h7FFF, 16'h7FFF},
         '{16'h8000, 16'h8000}, '{16'h7FFF, 16'h8000}, '{16'h8000, 16'h7FFF},
         '{16'h1000, 16'h0800}, '{16'hF000, 16'h0800}, '{16'h1000, 16'hF800},
         '{16'hF000, 16'hF800}, '{16'h0100, 16'h2000}, '{16'h0100, 16'hE000},
         '{16'h0001, 16'h0000}, '{16'hFFFF, 16'h0000}, '{16'h0000, 16'h0001},
         '{16'h0000, 16'hFFFF}, '{16'h4000, 16'h4000}, '{16'hC000, 16'h4000},
         '{16'h5555, 16'hAAAA}};
      for (i = 0; i < 22; i++) send_sample(directed[i][0], directed[i][1], 1'b0);
      stop_sending();
      wait_until_drained();

      periods = '{16'd0, 16'd1, 16'd65535, 16'd40000, 16'd5000};
      for (phase = 0; phase < 5; phase++) begin
         write_period(periods[phase]);
         n = (phase == 4) ? 450 : 200;
         calm_receiver = (phase == 2);
         for (i = 0; i < n; i++)
            send_sample(random_voltage(), random_voltage(), phase != 2);
         stop_sending();
         wait_until_drained();
      end

      if (board.errors == 0 && board.pending.size() == 0)
         $display("svpwm_compare_times_tb passed");
      else
         $display("svpwm_compare_times_tb failed");
      $finish;
   end
endmodule
